[rtl/sdl_pkg.sv]
`timescale 1ns / 1ps
// Package for the sorted descending list: sizes, request and status codes,
// and the control struct handed from the top level to every cell. No dependencies.
package sdl_pkg;

  localparam int DEPTH   = 16;
  localparam int VAL_W   = 32;
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 4;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  // Only the first cells are reachable by a read index.
  localparam int RD_N    = (DEPTH < (1 << IDX_W)) ? DEPTH : (1 << IDX_W);
  localparam int IN_W    = ((REQ_W + VAL_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_W   = ((STAT_W + VAL_W + OCC_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  // Per-cycle command broadcast to all cells.
  typedef struct packed {
    logic ins_en;   // insert accepted and list not full
    logic rem_en;   // remove accepted and a match exists
  } sdl_ctrl_t;

endpackage

[rtl/sorted_descending_list.sv]
`timescale 1ns / 1ps
// Top level of the sorted descending list: a row of sdl_cell instances,
// the entry count, request decode and the registered result. Depends on sdl_pkg, sdl_cell.
//
//  Channel  | Direction | Signals                  | Payload
//  ---------+-----------+--------------------------+----------------------------------
//  request  | in        | s_tvalid/s_tready/s_tdata| req_type, value, index
//  result   | out       | m_tvalid/m_tready/m_tdata| status, read_value, occupancy
//
// Each request is handled in the cycle it is accepted: all cells compare the
// request value against their entry in parallel and shift one place at once.
// The result is registered, so it appears in the cycle after the transfer and a
// new request can be taken in every cycle while the result side keeps up.
// A stalled result (m_tready low) holds s_tready low until it is taken.
// Reset (rst, synchronous) empties the list and drops any pending result.
module sorted_descending_list (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [sdl_pkg::IN_W-1:0]   s_tdata,   // [1:0] req_type, [33:2] value, [37:34] index
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sdl_pkg::OUT_W-1:0]  m_tdata    // [1:0] status, [33:2] read_value, [38:34] occupancy
);

  localparam int VW = sdl_pkg::VAL_W;

  // Request fields
  sdl_pkg::req_t                     req_type;
  logic signed [VW-1:0]              value;
  logic [sdl_pkg::IDX_W-1:0]         index;

  assign req_type = sdl_pkg::req_t'(s_tdata[sdl_pkg::REQ_W-1:0]);
  assign value    = s_tdata[sdl_pkg::REQ_W +: VW];
  assign index    = s_tdata[sdl_pkg::REQ_W + VW +: sdl_pkg::IDX_W];

  // Entry count and cell row
  logic [sdl_pkg::CNT_W-1:0]         count;
  logic [sdl_pkg::CNT_W-1:0]         count_next;
  logic signed [VW-1:0]              cell_val [sdl_pkg::DEPTH];
  logic [sdl_pkg::DEPTH-1:0]         cell_gt;
  logic [sdl_pkg::DEPTH-1:0]         cell_match;
  sdl_pkg::sdl_ctrl_t                ctrl;

  // Result register
  sdl_pkg::status_t                  status;
  logic signed [VW-1:0]              read_value;
  logic [sdl_pkg::OCC_W-1:0]         occupancy;
  sdl_pkg::status_t                  status_next;
  logic signed [VW-1:0]              read_value_next;

  logic                              accept;
  logic                              full;
  logic                              found;
  logic                              in_range;
  logic signed [VW-1:0]              rd_mux;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (int'(count) >= sdl_pkg::DEPTH);
  assign found    = |cell_match;
  assign in_range = (int'(index) < int'(count));

  // Cell i is occupied when i < count; cell 0 always sees a "keeping" left
  // neighbor so that it takes the new value at the head.
  for (genvar i = 0; i < sdl_pkg::DEPTH; i++) begin : g_cell
    logic                 left_gt;
    logic signed [VW-1:0] left_value;
    logic signed [VW-1:0] right_value;
    logic                 occupied;

    assign occupied = (i < int'(count));
    if (i == 0) begin : g_head
      assign left_gt    = 1'b1;
      assign left_value = value;
    end else begin : g_mid
      assign left_gt    = cell_gt[i-1];
      assign left_value = cell_val[i-1];
    end
    if (i == sdl_pkg::DEPTH - 1) begin : g_tail
      assign right_value = cell_val[i];   // past the tail: content does not matter
    end else begin : g_body
      assign right_value = cell_val[i+1];
    end

    sdl_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .din         (value),
      .occupied    (occupied),
      .left_gt     (left_gt),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_val[i]),
      .gt          (cell_gt[i]),
      .match       (cell_match[i])
    );
  end

  // Read mux over the cells an index can reach
  always_comb begin
    rd_mux = '0;
    for (int j = 0; j < sdl_pkg::RD_N; j++) begin
      if (int'(index) == j) begin
        rd_mux = cell_val[j];
      end
    end
  end

  // Request decode
  always_comb begin
    ctrl            = '0;
    count_next      = count;
    status_next     = sdl_pkg::ST_OK;
    read_value_next = '0;
    unique case (req_type)
      sdl_pkg::REQ_INSERT: begin
        if (full) begin
          status_next = sdl_pkg::ST_FULL;
        end else begin
          ctrl.ins_en = accept;
          count_next  = count + 1'b1;
        end
      end
      sdl_pkg::REQ_REMOVE: begin
        if (found) begin
          ctrl.rem_en = accept;
          count_next  = count - 1'b1;
        end else begin
          status_next = sdl_pkg::ST_MISSING;
        end
      end
      sdl_pkg::REQ_READ: begin
        if (in_range) begin
          read_value_next = rd_mux;
        end else begin
          status_next = sdl_pkg::ST_RANGE;
        end
      end
      sdl_pkg::REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload; occupancy shows the count modulo 32
  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      read_value <= read_value_next;
      occupancy  <= sdl_pkg::OCC_W'(count_next);
    end
  end

  assign m_tdata = sdl_pkg::OUT_W'({occupancy, read_value, status});

endmodule

[rtl/sdl_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the sorted list: holds one entry, compares it with the
// broadcast value and shifts to or from its neighbors. Depends on sdl_pkg.
module sdl_cell (
  input  logic                           clk,
  input  sdl_pkg::sdl_ctrl_t             ctrl,
  input  logic signed [sdl_pkg::VAL_W-1:0] din,
  input  logic                           occupied,   // cell lies below the count
  input  logic                           left_gt,    // neighbor toward head keeps
  input  logic signed [sdl_pkg::VAL_W-1:0] left_value,
  input  logic signed [sdl_pkg::VAL_W-1:0] right_value,
  output logic signed [sdl_pkg::VAL_W-1:0] value,
  output logic                           gt,
  output logic                           match
);

  logic signed [sdl_pkg::VAL_W-1:0] value_next;

  assign gt    = occupied && (value > din);
  assign match = occupied && (value == din);

  // Cells ahead of the insert/remove point hold; the rest shift by one.
  always_comb begin
    value_next = value;
    if (ctrl.ins_en && !gt) begin
      value_next = left_gt ? din : left_value;
    end else if (ctrl.rem_en && !gt) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
